FILE: hdl/clle_pkg.sv
// Shared constants, command codes and store write bundle for the cursor linked list engine.
// Depends on nothing; every other file of the engine imports it.
`default_nettype none

package clle_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int PTR_W    = IDX_W + 1;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 4;
   localparam int STAT_W   = 2;

   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_HEAD   = 4'd0,
      CMD_ADD_TAIL   = 4'd1,
      CMD_ADD_AFTER  = 4'd2,
      CMD_REM_HEAD   = 4'd3,
      CMD_REM_TAIL   = 4'd4,
      CMD_REM_CUR    = 4'd5,
      CMD_READ_HEAD  = 4'd6,
      CMD_READ_TAIL  = 4'd7,
      CMD_READ_CUR   = 4'd8,
      CMD_CUR_HEAD   = 4'd9,
      CMD_CUR_TAIL   = 4'd10,
      CMD_CUR_FWD    = 4'd11,
      CMD_CUR_BACK   = 4'd12
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_END   = 2'd3
   } status_type;

   // Write requests into the entry stores for one command.
   typedef struct packed {
      logic             data_en;
      logic [IDX_W-1:0] data_addr;
      logic [DATA_W-1:0] data_val;
      logic             next_a_en;
      logic [IDX_W-1:0] next_a_addr;
      logic [PTR_W-1:0] next_a_val;
      logic             next_b_en;
      logic [IDX_W-1:0] next_b_addr;
      logic [PTR_W-1:0] next_b_val;
      logic             prev_a_en;
      logic [IDX_W-1:0] prev_a_addr;
      logic [PTR_W-1:0] prev_a_val;
      logic             prev_b_en;
      logic [IDX_W-1:0] prev_b_addr;
      logic [PTR_W-1:0] prev_b_val;
   } store_wr_type;

   // Free list control from the command logic.
   typedef struct packed {
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] push_idx;
   } free_req_type;

   function automatic logic ptr_valid(input logic [PTR_W-1:0] p);
      return p < NULL_PTR;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/clle_store.sv
// Entry stores of the list: data word, next link and previous link per entry.
// Depends on clle_pkg for widths and the write bundle.
`default_nettype none

module clle_store (
   input  wire logic                   clock,
   input  wire clle_pkg::store_wr_type wr,
   input  wire logic [clle_pkg::IDX_W-1:0]  rd_addr,
   output logic [clle_pkg::DATA_W-1:0]      rd_data,
   output logic [clle_pkg::PTR_W-1:0]       rd_next,
   output logic [clle_pkg::PTR_W-1:0]       rd_prev
);
   import clle_pkg::*;

   logic [DATA_W-1:0] entry_data_ff [CAPACITY];
   logic [PTR_W-1:0]  next_link_ff  [CAPACITY];
   logic [PTR_W-1:0]  prev_link_ff  [CAPACITY];

   // Contents are undefined until an insert writes them.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (wr.data_en && wr.data_addr == IDX_W'(i)) begin
            entry_data_ff[i] <= wr.data_val;
         end
         if (wr.next_a_en && wr.next_a_addr == IDX_W'(i)) begin
            next_link_ff[i] <= wr.next_a_val;
         end else if (wr.next_b_en && wr.next_b_addr == IDX_W'(i)) begin
            next_link_ff[i] <= wr.next_b_val;
         end
         if (wr.prev_a_en && wr.prev_a_addr == IDX_W'(i)) begin
            prev_link_ff[i] <= wr.prev_a_val;
         end else if (wr.prev_b_en && wr.prev_b_addr == IDX_W'(i)) begin
            prev_link_ff[i] <= wr.prev_b_val;
         end
      end
   end

   assign rd_data = entry_data_ff[rd_addr];
   assign rd_next = next_link_ff[rd_addr];
   assign rd_prev = prev_link_ff[rd_addr];

endmodule

`default_nettype wire

FILE: hdl/clle_free.sv
// Stack of free entry indices, reset to every index in ascending order.
// Depends on clle_pkg for widths and the request bundle.
`default_nettype none

module clle_free (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire clle_pkg::free_req_type req,
   output logic [clle_pkg::IDX_W-1:0]  top_idx
);
   import clle_pkg::*;

   logic [IDX_W-1:0] free_stack_ff [CAPACITY];
   logic [PTR_W-1:0] free_count_ff;
   logic [PTR_W-1:0] free_count_in;
   logic [PTR_W-1:0] count_less;

   assign count_less = free_count_ff - PTR_W'(1);
   assign top_idx    = free_stack_ff[count_less[IDX_W-1:0]];

   always_comb begin
      free_count_in = free_count_ff;
      if (req.pop && free_count_ff != '0) begin
         free_count_in = count_less;
      end else if (req.push && free_count_ff < NULL_PTR) begin
         free_count_in = free_count_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= NULL_PTR;
         for (int i = 0; i < CAPACITY; i++) begin
            free_stack_ff[i] <= IDX_W'(i);
         end
      end else begin
         free_count_ff <= free_count_in;
         if (!req.pop && req.push && free_count_ff < NULL_PTR) begin
            free_stack_ff[free_count_ff[IDX_W-1:0]] <= req.push_idx;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/clle_exec.sv
// Command logic and list pointers: decodes one command, drives the store and free list writes.
// Depends on clle_pkg, and is wired to clle_store and clle_free by the top level.
`default_nettype none

module clle_exec (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     go,
   input  wire logic [clle_pkg::CMD_W-1:0]  cmd,
   input  wire logic [clle_pkg::DATA_W-1:0] value,
   output logic [clle_pkg::IDX_W-1:0]    rd_addr,
   input  wire logic [clle_pkg::DATA_W-1:0] rd_data,
   input  wire logic [clle_pkg::PTR_W-1:0]  rd_next,
   input  wire logic [clle_pkg::PTR_W-1:0]  rd_prev,
   output clle_pkg::store_wr_type        wr,
   output clle_pkg::free_req_type        free_req,
   input  wire logic [clle_pkg::IDX_W-1:0]  free_top,
   output logic [clle_pkg::DATA_W-1:0]   out_value,
   output logic [clle_pkg::PTR_W-1:0]    list_length,
   output logic [clle_pkg::STAT_W-1:0]   status
);
   import clle_pkg::*;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] cursor_ff, cursor_in;
   logic [PTR_W-1:0] count_ff, count_in;

   cmd_type          op;
   status_type       stat;
   logic             empty;
   logic [PTR_W-1:0] target;
   logic [PTR_W-1:0] left_ptr;
   logic [PTR_W-1:0] right_ptr;
   logic [PTR_W-1:0] new_idx;

   assign op      = cmd_type'(cmd);
   assign empty   = (count_ff == '0);
   assign new_idx = {1'b0, free_top};

   // The one entry a command looks at: the cursor, the head or the tail.
   always_comb begin
      unique case (op)
         CMD_REM_HEAD, CMD_READ_HEAD: target = head_ff;
         CMD_REM_TAIL, CMD_READ_TAIL: target = tail_ff;
         default:                     target = cursor_ff;
      endcase
   end
   assign rd_addr = target[IDX_W-1:0];

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      cursor_in = cursor_ff;
      count_in  = count_ff;
      stat      = STAT_OK;
      out_value = '0;
      wr        = '0;
      free_req  = '0;
      left_ptr  = NULL_PTR;
      right_ptr = NULL_PTR;

      if (go) begin
         if (cmd <= CMD_ADD_AFTER) begin
            if (count_ff >= NULL_PTR) begin
               stat = STAT_FULL;
            end else begin
               priority if (empty) begin
                  left_ptr  = NULL_PTR;
                  right_ptr = NULL_PTR;
                  cursor_in = new_idx;
               end else if (op == CMD_ADD_HEAD) begin
                  right_ptr = head_ff;
               end else if (op == CMD_ADD_TAIL) begin
                  left_ptr = tail_ff;
               end else begin
                  left_ptr  = cursor_ff;
                  right_ptr = rd_next;
                  cursor_in = new_idx;
               end
               free_req.pop   = 1'b1;
               wr.data_en     = 1'b1;
               wr.data_addr   = free_top;
               wr.data_val    = value;
               wr.next_a_en   = 1'b1;
               wr.next_a_addr = free_top;
               wr.next_a_val  = right_ptr;
               wr.prev_a_en   = 1'b1;
               wr.prev_a_addr = free_top;
               wr.prev_a_val  = left_ptr;
               if (ptr_valid(left_ptr)) begin
                  wr.next_b_en   = 1'b1;
                  wr.next_b_addr = left_ptr[IDX_W-1:0];
                  wr.next_b_val  = new_idx;
               end else begin
                  head_in = new_idx;
               end
               if (ptr_valid(right_ptr)) begin
                  wr.prev_b_en   = 1'b1;
                  wr.prev_b_addr = right_ptr[IDX_W-1:0];
                  wr.prev_b_val  = new_idx;
               end else begin
                  tail_in = new_idx;
               end
               count_in = count_ff + PTR_W'(1);
            end
         end else if (cmd <= CMD_CUR_BACK && empty) begin
            stat = STAT_EMPTY;
         end else begin
            unique case (op)
               CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_CUR: begin
                  if (ptr_valid(target)) begin
                     out_value = rd_data;
                     if (ptr_valid(rd_prev)) begin
                        wr.next_b_en   = 1'b1;
                        wr.next_b_addr = rd_prev[IDX_W-1:0];
                        wr.next_b_val  = rd_next;
                     end else begin
                        head_in = rd_next;
                     end
                     if (ptr_valid(rd_next)) begin
                        wr.prev_b_en   = 1'b1;
                        wr.prev_b_addr = rd_next[IDX_W-1:0];
                        wr.prev_b_val  = rd_prev;
                     end else begin
                        tail_in = rd_prev;
                     end
                     free_req.push     = 1'b1;
                     free_req.push_idx = target[IDX_W-1:0];
                     count_in = count_ff - PTR_W'(1);
                     if (count_in == '0) begin
                        head_in = NULL_PTR;
                        tail_in = NULL_PTR;
                     end
                     // Any removal sends the cursor back to the head.
                     cursor_in = head_in;
                  end
               end
               CMD_READ_HEAD, CMD_READ_TAIL, CMD_READ_CUR: begin
                  if (ptr_valid(target)) begin
                     out_value = rd_data;
                  end
               end
               CMD_CUR_HEAD: cursor_in = head_ff;
               CMD_CUR_TAIL: cursor_in = tail_ff;
               CMD_CUR_FWD: begin
                  if (ptr_valid(cursor_ff) && ptr_valid(rd_next)) begin
                     cursor_in = rd_next;
                  end else begin
                     stat = STAT_END;
                  end
               end
               CMD_CUR_BACK: begin
                  if (ptr_valid(cursor_ff) && ptr_valid(rd_prev)) begin
                     cursor_in = rd_prev;
                  end else begin
                     stat = STAT_END;
                  end
               end
               default: begin
                  stat = STAT_OK;
               end
            endcase
         end
      end
   end

   assign list_length = count_in;
   assign status      = stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= NULL_PTR;
         tail_ff   <= NULL_PTR;
         cursor_ff <= NULL_PTR;
         count_ff  <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cursor_linked_list_engine_unit.sv
// Top level of the cursor linked list engine: input register, command logic, result register.
// Depends on clle_pkg, clle_store, clle_free and clle_exec.
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_command, req_item_value
// rsp_      out        rsp_valid/rsp_stall  rsp_out_value, rsp_list_length, rsp_status
//
// An accepted item sits in the input register; the whole command is then decoded and the
// list updated in a single pass that loads the result register once that register is free
// or being emptied. A new item may enter in every cycle while rsp_stall holds no waiting
// result, so the sustained rate is one item per cycle. Reset is synchronous and active high;
// it empties the list and refills the free stack at once. When rsp_stall holds a waiting
// result, the item in the input register waits too and req_stall rises; nothing else is
// lost or repeated.

module cursor_linked_list_engine_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [clle_pkg::CMD_W-1:0]    req_command,
   input  wire logic [clle_pkg::DATA_W-1:0]   req_item_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [clle_pkg::DATA_W-1:0]        rsp_out_value,
   output logic [clle_pkg::PTR_W-1:0]         rsp_list_length,
   output logic [clle_pkg::STAT_W-1:0]        rsp_status
);
   import clle_pkg::*;

   // Input register holding the item waiting to be executed.
   logic              in_valid_ff;
   logic [CMD_W-1:0]  in_cmd_ff;
   logic [DATA_W-1:0] in_value_ff;

   // Result register facing the output channel.
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_value_ff;
   logic [PTR_W-1:0]  out_length_ff;
   logic [STAT_W-1:0] out_status_ff;

   // The held item executes when the result register is free or being emptied.
   logic advance;

   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [PTR_W-1:0]  rd_next;
   logic [PTR_W-1:0]  rd_prev;
   store_wr_type      wr;
   free_req_type      free_req;
   logic [IDX_W-1:0]  free_top;
   logic [DATA_W-1:0] exec_value;
   logic [PTR_W-1:0]  exec_length;
   logic [STAT_W-1:0] exec_status;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   clle_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rd_next (rd_next),
      .rd_prev (rd_prev)
   );

   clle_free u_free (
      .clock   (clock),
      .reset   (reset),
      .req     (free_req),
      .top_idx (free_top)
   );

   clle_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .go          (advance),
      .cmd         (in_cmd_ff),
      .value       (in_value_ff),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rd_next     (rd_next),
      .rd_prev     (rd_prev),
      .wr          (wr),
      .free_req    (free_req),
      .free_top    (free_top),
      .out_value   (exec_value),
      .list_length (exec_length),
      .status      (exec_status)
   );

   // The input register reloads whenever it is not stalled; a bubble simply clears valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_cmd_ff   <= req_command;
         in_value_ff <= req_item_value;
      end
   end

   // The result register takes the executed item, or drains once its item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_value_ff  <= exec_value;
         out_length_ff <= exec_length;
         out_status_ff <= exec_status;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_list_length = out_length_ff;
   assign rsp_status      = out_status_ff;

endmodule

`default_nettype wire
